// File: hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and constants of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CAPACITY_DEFAULT = 32;

	typedef enum logic [3:0] {
		CMD_INSERT_AT = 4'd0,
		CMD_INSERT_FIRST = 4'd1,
		CMD_INSERT_LAST = 4'd2,
		CMD_DELETE = 4'd3,
		CMD_CLEAR = 4'd4,
		CMD_REPLACE = 4'd5,
		CMD_SEARCH = 4'd6,
		CMD_LENGTH = 4'd7,
		CMD_DUMP = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_BADPOS = 3'd1,
		ST_EMPTYPOS = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_LISTEMPTY = 3'd4,
		ST_FULL = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_DUMP
	} fsm_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture command
		logic exec;      // run captured command on the cells
		logic dump_step; // advance dump index
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_dump;
		logic is_valid_cmd;
		logic dump_empty;
		logic dump_last;
	} dp_status_t;

endpackage

// File: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// bounded ordered list of signed 32-bit values with 1-based positions
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command item: cmd, position, value. m_axis returns the
//   result items; every command but dump gives one item, a dump gives one
//   item per entry (one item with status list empty if there are none), and
//   tlast marks the final item of a command. unknown codes give no item.
//   timing: a command is taken in idle and run on the cell row in exec,
//   once the result slot is free; no new command is taken before then, and
//   all cells shift and compare in parallel.
//   a dump reads its result items from the cells one index a cycle while
//   the result slot is free.
//   the result register holds its item while m_axis_tready is low; a new
//   command is still taken but waits in exec until the pending item leaves.
//   reset clears the entry count and the sequencer; cell contents are
//   left as they are and are never read beyond the count.
// ----------------------------------------------------------------------------
module positional_list_engine #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] cmd, [11:4] position, [43:12] value, [47:44] zero
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] status, [9:3] found_position, [41:10] entry_value, [48:42] count,
	// [55:49] zero
	output logic [55:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	ple_pkg::dp_cmd_t    ctl;
	ple_pkg::dp_status_t stat;
	logic [2:0]  res_status;
	logic [6:0]  res_found_position;
	logic [31:0] res_entry_value;
	logic [6:0]  res_count;
	logic        res_last;

	ple_control u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctl       (ctl),
		.stat      (stat),
		.res_last  (res_last)
	);

	ple_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.stat               (stat),
		.in_cmd             (s_axis_tdata[3:0]),
		.in_position        (s_axis_tdata[11:4]),
		.in_value           (s_axis_tdata[43:12]),
		.res_status         (res_status),
		.res_found_position (res_found_position),
		.res_entry_value    (res_entry_value),
		.res_count          (res_count),
		.res_last           (res_last)
	);

	assign m_axis_tdata = {7'd0, res_count, res_entry_value, res_found_position, res_status};
	assign m_axis_tlast = res_last;

endmodule

// File: hw/rtl/ple_datapath.sv
// ----------------------------------------------------------------------------
// ple_datapath
// row of cells with parallel shift and compare, count and result formation
// ----------------------------------------------------------------------------
module ple_datapath #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ple_pkg::dp_cmd_t    ctl,
	output ple_pkg::dp_status_t stat,
	input  logic [3:0]          in_cmd,
	input  logic [7:0]          in_position,
	input  logic [31:0]         in_value,
	output logic [2:0]          res_status,
	output logic [6:0]          res_found_position,
	output logic [31:0]         res_entry_value,
	output logic [6:0]          res_count,
	output logic                res_last
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	logic [31:0]   cells_q [CAPACITY];
	logic [CW-1:0] count_q;
	logic [3:0]    cmd_q;
	logic [7:0]    pos_q;
	logic [31:0]   val_q;
	logic [IW-1:0] dump_idx_q;

	// effective insert position and checks
	logic [8:0]    ipos;
	logic [8:0]    cnt9;
	logic          ins, del, rep, srch;
	logic          ok_ins, ok_del, ok_rep;
	logic [2:0]    st;
	logic [CAPACITY-1:0] match;
	logic [6:0]    hit;

	assign cnt9 = 9'(count_q);
	assign ins  = (cmd_q == ple_pkg::CMD_INSERT_AT) || (cmd_q == ple_pkg::CMD_INSERT_FIRST) ||
		(cmd_q == ple_pkg::CMD_INSERT_LAST);
	assign del  = cmd_q == ple_pkg::CMD_DELETE;
	assign rep  = cmd_q == ple_pkg::CMD_REPLACE;
	assign srch = cmd_q == ple_pkg::CMD_SEARCH;

	always_comb begin
		unique case (cmd_q)
			ple_pkg::CMD_INSERT_FIRST: ipos = 9'd1;
			ple_pkg::CMD_INSERT_LAST:  ipos = cnt9 + 9'd1;
			default:                   ipos = {1'b0, pos_q};
		endcase
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++)
			match[i] = (i < int'(count_q)) && (cells_q[i] == val_q);
	end

	// first hit as a 1-based position, lowest matching cell has priority
	always_comb begin
		hit = '0;
		for (int i = CAPACITY - 1; i >= 0; i--)
			if (match[i]) hit = 7'(i + 1);
	end

	always_comb begin
		ok_ins = 1'b0;
		ok_del = 1'b0;
		ok_rep = 1'b0;
		st = ple_pkg::ST_OK;
		if (ins) begin
			if (ipos == 9'd0 || ipos > cnt9 + 9'd1) st = ple_pkg::ST_BADPOS;
			else if (cnt9 >= 9'(CAPACITY)) st = ple_pkg::ST_FULL;
			else ok_ins = 1'b1;
		end else if (del || rep) begin
			if (pos_q == 8'd0) st = ple_pkg::ST_BADPOS;
			else if ({1'b0, pos_q} > cnt9) st = ple_pkg::ST_EMPTYPOS;
			else begin
				ok_del = del;
				ok_rep = rep;
			end
		end else if (srch) begin
			st = (match == '0) ? ple_pkg::ST_NOTFOUND : ple_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= in_cmd;
			pos_q <= in_position;
			val_q <= in_value;
		end
		if (ctl.exec) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (ok_ins) begin
					if (9'(i + 1) == ipos) cells_q[i] <= val_q;
					else if (9'(i + 1) > ipos && i > 0) cells_q[i] <= cells_q[i-1];
				end else if (ok_del) begin
					if (9'(i + 1) >= {1'b0, pos_q} && i < CAPACITY - 1)
						cells_q[i] <= cells_q[i+1];
				end else if (ok_rep) begin
					if (9'(i + 1) == {1'b0, pos_q}) cells_q[i] <= val_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dump_idx_q <= '0;
		end else begin
			if (ctl.load) dump_idx_q <= '0;
			else if (ctl.dump_step) dump_idx_q <= dump_idx_q + 1'b1;
			if (ctl.exec) begin
				if (ok_ins) count_q <= count_q + 1'b1;
				else if (ok_del) count_q <= count_q - 1'b1;
				else if (cmd_q == ple_pkg::CMD_CLEAR) count_q <= '0;
			end
		end
	end

	assign stat.is_dump = cmd_q == ple_pkg::CMD_DUMP;
	assign stat.is_valid_cmd = cmd_q <= ple_pkg::CMD_DUMP;
	assign stat.dump_empty = count_q == '0;
	assign stat.dump_last = CW'(dump_idx_q) + 1'b1 == count_q;

	// result of the next cycle after exec, or of the current dump cell
	always_ff @(posedge clk) begin
		if (ctl.exec && !stat.is_dump) begin
			res_status <= st;
			res_found_position <= srch ? hit : 7'd0;
			res_entry_value <= '0;
			res_last <= 1'b1;
			if (ok_ins) res_count <= 7'(count_q + 1'b1);
			else if (ok_del) res_count <= 7'(count_q - 1'b1);
			else if (cmd_q == ple_pkg::CMD_CLEAR) res_count <= '0;
			else res_count <= 7'(count_q);
		end else if (ctl.dump_step) begin
			res_count <= 7'(count_q);
			if (stat.dump_empty) begin
				res_status <= ple_pkg::ST_LISTEMPTY;
				res_found_position <= '0;
				res_entry_value <= '0;
				res_last <= 1'b1;
			end else begin
				res_status <= ple_pkg::ST_OK;
				res_found_position <= 7'(dump_idx_q) + 7'd1;
				res_entry_value <= cells_q[dump_idx_q];
				res_last <= stat.dump_last;
			end
		end
	end

endmodule

// File: hw/rtl/ple_control.sv
// ----------------------------------------------------------------------------
// ple_control
// command sequencer and output valid handling
// ----------------------------------------------------------------------------
module ple_control (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output ple_pkg::dp_cmd_t    ctl,
	input  ple_pkg::dp_status_t stat,
	input  logic                res_last
);

	ple_pkg::fsm_state_t state_q, state_d;
	logic out_valid_q, out_valid_d;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ple_pkg::FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid_q && !out_ready;
		ctl = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ple_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d = ple_pkg::FSM_EXEC;
				end
			end
			ple_pkg::FSM_EXEC: begin
				if (!stat.is_valid_cmd) begin
					state_d = ple_pkg::FSM_IDLE;
				end else if (stat.is_dump) begin
					// enter the dump only once the previous item has left
					if (slot_free) state_d = ple_pkg::FSM_DUMP;
				end else if (slot_free) begin
					ctl.exec = 1'b1;
					out_valid_d = 1'b1;
					state_d = ple_pkg::FSM_IDLE;
				end
			end
			ple_pkg::FSM_DUMP: begin
				// once the last dump item is out, stop
				if (out_valid_q && out_ready && res_last) begin
					state_d = ple_pkg::FSM_IDLE;
				end else if (slot_free && !(out_valid_q && res_last)) begin
					ctl.dump_step = 1'b1;
					out_valid_d = 1'b1;
				end
			end
			default: state_d = ple_pkg::FSM_IDLE;
		endcase
	end

endmodule

// File: tb/tb_positional_list_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// self-checking bench for the positional list engine
// ----------------------------------------------------------------------------
// commands go in through a driver fed from a queue, results are checked by a
// monitor against a list model kept in the bench; random gaps on both sides
// ----------------------------------------------------------------------------
module tb_positional_list_engine;

	localparam int CAP = ple_pkg::CAPACITY_DEFAULT;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [7:0]  position;
		logic [31:0] value;
	} command_t;

	typedef struct packed {
		ple_pkg::status_t status;
		logic [6:0]  found_position;
		logic [31:0] entry_value;
		logic [6:0]  count;
		logic        last;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;

	command_t    pending_cmds[$];
	answer_t     expected_answers[$];
	logic [31:0] list_cells[CAP];
	int          list_len = 0;
	int          fail_count = 0;
	int          answers_seen = 0;
	int          commands_sent = 0;
	int          cycle_count = 0;
	int          send_gap = 0;
	int          recv_gap = 0;
	bit          stimulus_done = 0;
	bit          in_taken = 0;

	positional_list_engine i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void push_answer(ple_pkg::status_t st, int pos, logic [31:0] val,
		logic lst);
		answer_t a;
		a.status = st;
		a.found_position = pos[6:0];
		a.entry_value = val;
		a.count = list_len[6:0];
		a.last = lst;
		expected_answers.push_back(a);
	endfunction

	function automatic ple_pkg::status_t list_insert(int pos, logic [31:0] val);
		if (pos == 0 || pos > list_len + 1) return ple_pkg::ST_BADPOS;
		if (list_len >= CAP) return ple_pkg::ST_FULL;
		for (int i = list_len; i >= pos; i--) list_cells[i] = list_cells[i - 1];
		list_cells[pos - 1] = val;
		list_len++;
		return ple_pkg::ST_OK;
	endfunction

	// updates the list model and queues the answers a command causes
	function automatic void apply_command(command_t c);
		ple_pkg::status_t st;
		int hit;
		st = ple_pkg::ST_OK;
		hit = 0;
		case (c.cmd)
			ple_pkg::CMD_INSERT_AT: st = list_insert(c.position, c.value);
			ple_pkg::CMD_INSERT_FIRST: st = list_insert(1, c.value);
			ple_pkg::CMD_INSERT_LAST: st = list_insert(list_len + 1, c.value);
			ple_pkg::CMD_DELETE, ple_pkg::CMD_REPLACE: begin
				if (c.position == 0) st = ple_pkg::ST_BADPOS;
				else if (c.position > list_len) st = ple_pkg::ST_EMPTYPOS;
				else if (c.cmd == ple_pkg::CMD_REPLACE) list_cells[c.position - 1] = c.value;
				else begin
					for (int i = c.position; i < list_len; i++) list_cells[i - 1] = list_cells[i];
					list_len--;
				end
			end
			ple_pkg::CMD_CLEAR: list_len = 0;
			ple_pkg::CMD_SEARCH: begin
				st = ple_pkg::ST_NOTFOUND;
				for (int i = 0; i < list_len; i++)
					if (hit == 0 && list_cells[i] == c.value) begin
						st = ple_pkg::ST_OK;
						hit = i + 1;
					end
			end
			ple_pkg::CMD_LENGTH: ;
			ple_pkg::CMD_DUMP: begin
				if (list_len == 0) push_answer(ple_pkg::ST_LISTEMPTY, 0, '0, 1'b1);
				for (int i = 0; i < list_len; i++)
					push_answer(ple_pkg::ST_OK, i + 1, list_cells[i], i + 1 == list_len);
				return;
			end
			default: return; // unknown codes give nothing
		endcase
		push_answer(st, hit, '0, 1'b1);
	endfunction

	function automatic void add_cmd(ple_pkg::cmd_t k, int pos, logic [31:0] val);
		command_t c;
		c.cmd = k;
		c.position = pos[7:0];
		c.value = val;
		pending_cmds.push_back(c);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			default: return $urandom_range(0, 7); // small pool so searches hit
		endcase
	endfunction

	// driver: acceptance is taken from the rising edge sample
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !in_taken) begin
				// hold the item
			end else if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				s_axis_tdata <= {4'b0, pending_cmds[0].value, pending_cmds[0].position,
					pending_cmds[0].cmd};
				s_axis_tvalid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
			in_taken = 1'b0;
			if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_gap = pick_gap();
			end
		end
	end

	// input handshake sampled here, model updated on acceptance
	// monitor: results checked at the rising edge
	always @(posedge clk) begin
		answer_t got, want;
		cycle_count++;
		if (s_axis_tvalid && s_axis_tready) begin
			apply_command(pending_cmds.pop_front());
			commands_sent++;
			in_taken = 1'b1;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.status = ple_pkg::status_t'(m_axis_tdata[2:0]);
			got.found_position = m_axis_tdata[9:3];
			got.entry_value = m_axis_tdata[41:10];
			got.count = m_axis_tdata[48:42];
			got.last = m_axis_tlast;
			if (expected_answers.size() == 0) begin
				$error("result item with nothing expected: %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = expected_answers.pop_front();
				answers_seen++;
				if (got.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, got.status);
					fail_count++;
				end
				if (got.found_position !== want.found_position) begin
					$error("found_position expected %0d actual %0d",
						want.found_position, got.found_position);
					fail_count++;
				end
				if (got.entry_value !== want.entry_value) begin
					$error("entry_value expected %0d actual %0d",
						$signed(want.entry_value), $signed(got.entry_value));
					fail_count++;
				end
				if (got.count !== want.count) begin
					$error("count expected %0d actual %0d", want.count, got.count);
					fail_count++;
				end
				if (got.last !== want.last) begin
					$error("last expected %0d actual %0d", want.last, got.last);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int r;
		// directed part: empty list cases, extremes, fill to full
		add_cmd(ple_pkg::CMD_DUMP, 0, '0);
		add_cmd(ple_pkg::CMD_SEARCH, 0, 32'd5);
		add_cmd(ple_pkg::CMD_DELETE, 1, '0);
		add_cmd(ple_pkg::CMD_REPLACE, 0, '0);
		add_cmd(ple_pkg::CMD_INSERT_AT, 0, 32'd1);
		add_cmd(ple_pkg::CMD_INSERT_AT, 2, 32'd1);
		add_cmd(ple_pkg::CMD_INSERT_AT, 1, 32'h8000_0000);
		add_cmd(ple_pkg::CMD_INSERT_FIRST, 0, 32'h7fff_ffff);
		add_cmd(ple_pkg::CMD_INSERT_LAST, 255, 32'hffff_ffff);
		add_cmd(ple_pkg::CMD_INSERT_AT, 2, 32'h5555_aaaa);
		add_cmd(ple_pkg::CMD_REPLACE, 4, 32'haaaa_5555);
		add_cmd(ple_pkg::CMD_REPLACE, 5, 32'd9);
		add_cmd(ple_pkg::CMD_DELETE, 255, '0);
		add_cmd(ple_pkg::CMD_SEARCH, 0, 32'h7fff_ffff);
		add_cmd(ple_pkg::CMD_LENGTH, 0, '0);
		add_cmd(ple_pkg::CMD_DUMP, 0, '0);
		pending_cmds.push_back({4'd15, 8'hff, 32'hffff_ffff});
		add_cmd(ple_pkg::CMD_DELETE, 2, '0);
		for (int i = 0; i < CAP; i++) add_cmd(ple_pkg::CMD_INSERT_LAST, 0, i);
		add_cmd(ple_pkg::CMD_INSERT_AT, 1, '0);
		add_cmd(ple_pkg::CMD_INSERT_FIRST, 0, '0);
		add_cmd(ple_pkg::CMD_DUMP, 0, '0);
		add_cmd(ple_pkg::CMD_CLEAR, 0, '0);
		// random part, weighted toward edits that keep the list populated
		for (int n = 0; n < 206; n++) begin
			r = $urandom_range(0, 99);
			if (r < 22) add_cmd(ple_pkg::CMD_INSERT_AT, $urandom_range(0, 12), pick_value());
			else if (r < 30) add_cmd(ple_pkg::CMD_INSERT_FIRST, $urandom, pick_value());
			else if (r < 40) add_cmd(ple_pkg::CMD_INSERT_LAST, $urandom, pick_value());
			else if (r < 52) add_cmd(ple_pkg::CMD_DELETE, $urandom_range(0, 12), $urandom);
			else if (r < 54) add_cmd(ple_pkg::CMD_CLEAR, $urandom, $urandom);
			else if (r < 64) add_cmd(ple_pkg::CMD_REPLACE, $urandom_range(0, 12), pick_value());
			else if (r < 78) add_cmd(ple_pkg::CMD_SEARCH, $urandom, pick_value());
			else if (r < 84) add_cmd(ple_pkg::CMD_LENGTH, $urandom, $urandom);
			else if (r < 92) add_cmd(ple_pkg::CMD_DUMP, $urandom, $urandom);
			else if (r < 96)
				add_cmd(ple_pkg::cmd_t'($urandom_range(0, 8)), $urandom, $urandom);
			else pending_cmds.push_back({4'($urandom_range(9, 15)), 8'($urandom), 32'($urandom)});
		end
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (pending_cmds.size() != 0 || s_axis_tvalid || expected_answers.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		stimulus_done = 1;
	end

	initial begin
		wait (stimulus_done || cycle_count >= CYCLE_LIMIT);
		if (stimulus_done) begin
			$display("ran %0d commands, checked %0d result items", commands_sent,
				answers_seen);
			$display("covered all commands, position errors, full and empty list");
			if (fail_count == 0)
				$display("*** PASSED ***");
			else
				$display("*** FAILED ***");
		end else begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
